// ----- design/rrts_pkg.sv -----
// Package for the round-robin thread scheduler.
// Holds the shared codes, reset constants and controller/datapath structs.
// It has no dependencies.
`default_nettype none

package rrts_pkg;

  // Default number of thread slots.
  localparam int unsigned ThreadSlots = 4;

  // Widths fixed by the transaction fields.
  localparam int unsigned SpW     = 8;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned SlotW   = 2;
  localparam int unsigned PswW    = 5;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;

  // Reset values of the configuration registers.
  localparam logic [SpW-1:0] StackBaseRst   = 8'h3F;
  localparam logic [SpW-1:0] StackStrideRst = 8'h10;

  // Bytes of the initial frame pushed by the outside frame writer.
  localparam logic [SpW-1:0] FrameBytes = 8'd7;

  // Configuration register indexes, taken from paddr bit 2.
  typedef enum logic {
    REG_STACK_BASE   = 1'b0,
    REG_STACK_STRIDE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    FN_CREATE = 2'd0,
    FN_YIELD  = 2'd1,
    FN_EXIT   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NO_ACTIVE = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming transaction
    logic commit;  // update scheduler state and result registers
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic func_valid;  // captured function code produces a result
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/rrts_ctrl.sv -----
// Controller state machine of the round-robin thread scheduler.
// Depends on rrts_pkg for the command and status structs.
`default_nettype none

module rrts_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire rrts_pkg::dp_status_t status_i,
  output rrts_pkg::dp_cmd_t       cmd_o,
  output logic                    result_valid_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    valid_d     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.commit = 1'b1;
        valid_d      = status_i.func_valid;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign busy           = (state_q == S_EXEC);
  assign result_valid_o = valid_q;

endmodule

`default_nettype wire

// ----- design/rrts_datapath.sv -----
// Datapath of the round-robin thread scheduler: slot state, saved stack
// pointers, slot searches and result registers. Depends on rrts_pkg.
`default_nettype none

module rrts_datapath #(
  parameter int unsigned ThreadSlots = rrts_pkg::ThreadSlots
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rrts_pkg::dp_cmd_t             cmd_i,
  output rrts_pkg::dp_status_t               status_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [rrts_pkg::SpW-1:0]      current_sp_i,
  input  wire logic [rrts_pkg::AddrW-1:0]    entry_addr_i,
  input  wire logic [rrts_pkg::SpW-1:0]      stack_base_i,
  input  wire logic [rrts_pkg::SpW-1:0]      stack_stride_i,
  output logic [1:0]                         status_res_o,
  output logic [rrts_pkg::SlotW-1:0]         slot_id_o,
  output logic [rrts_pkg::SpW-1:0]           stack_ptr_o,
  output logic [rrts_pkg::PswW-1:0]          bank_psw_o,
  output logic [rrts_pkg::AddrW-1:0]         start_addr_o
);

  localparam int unsigned IdxW = $clog2(ThreadSlots);
  localparam int unsigned SpW  = rrts_pkg::SpW;

  // Captured transaction.
  logic [1:0]                 func_q;
  logic [SpW-1:0]             sp_q;
  logic [rrts_pkg::AddrW-1:0] entry_q;

  // Scheduler state.
  logic [ThreadSlots-1:0] active_q, active_d;
  logic [IdxW-1:0]        run_q, run_d;
  logic [SpW-1:0]         sp_tab_q [ThreadSlots];

  // Table write port.
  logic            tab_we;
  logic [IdxW-1:0] tab_waddr;
  logic [SpW-1:0]  tab_wdata;

  // Result next values.
  logic [1:0]                 res_status_d;
  logic [rrts_pkg::SlotW-1:0] res_slot_d;
  logic [SpW-1:0]             res_sp_d;
  logic [rrts_pkg::PswW-1:0]  res_psw_d;
  logic [rrts_pkg::AddrW-1:0] res_addr_d;

  // Lowest free slot.
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  logic [SpW-1:0]  init_sp;

  // Round-robin search.
  logic [ThreadSlots-1:0] run_bit;
  logic [ThreadSlots-1:0] srch_map;
  logic                   nx_found;
  logic [IdxW-1:0]        nx_idx;
  logic [IdxW:0]          cand;
  logic [SpW-1:0]         nx_sp;

  assign status_o.func_valid = (func_q == rrts_pkg::FN_CREATE) ||
                               (func_q == rrts_pkg::FN_YIELD) ||
                               (func_q == rrts_pkg::FN_EXIT);

  assign run_bit = ThreadSlots'(1) << run_q;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = ThreadSlots - 1; s >= 0; s--) begin
      if (!active_q[s]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(s);
      end
    end
  end

  assign init_sp = SpW'(stack_base_i + SpW'(stack_stride_i * SpW'(free_idx)) +
                        rrts_pkg::FrameBytes);

  // Exit searches the map with the running slot already cleared.
  assign srch_map = (func_q == rrts_pkg::FN_EXIT) ? (active_q & ~run_bit) : active_q;

  // Slots after the running one are tested first, the running slot last.
  always_comb begin
    nx_found = 1'b0;
    nx_idx   = '0;
    cand     = {1'b0, run_q};
    for (int k = 0; k < ThreadSlots; k++) begin
      cand = cand + 1'b1;
      if (cand == (IdxW + 1)'(ThreadSlots)) begin
        cand = '0;
      end
      if (!nx_found && srch_map[cand[IdxW-1:0]]) begin
        nx_found = 1'b1;
        nx_idx   = cand[IdxW-1:0];
      end
    end
  end

  // A yield that lands on the running slot returns the pointer it just saved.
  assign nx_sp = ((func_q == rrts_pkg::FN_YIELD) && (nx_idx == run_q)) ?
                 sp_q : sp_tab_q[nx_idx];

  always_comb begin
    active_d     = active_q;
    run_d        = run_q;
    tab_we       = 1'b0;
    tab_waddr    = run_q;
    tab_wdata    = sp_q;
    res_status_d = rrts_pkg::ST_OK;
    res_slot_d   = '0;
    res_sp_d     = '0;
    res_psw_d    = '0;
    res_addr_d   = '0;
    case (func_q)
      rrts_pkg::FN_CREATE: begin
        if (free_found) begin
          active_d  = active_q | (ThreadSlots'(1) << free_idx);
          tab_we    = 1'b1;
          tab_waddr = free_idx;
          tab_wdata = init_sp;
          res_slot_d = rrts_pkg::SlotW'(free_idx);
          res_sp_d   = init_sp;
          res_psw_d  = rrts_pkg::PswW'({res_slot_d, 3'b000});
          res_addr_d = entry_q;
        end else begin
          res_status_d = rrts_pkg::ST_NO_FREE;
        end
      end
      rrts_pkg::FN_YIELD, rrts_pkg::FN_EXIT: begin
        if (func_q == rrts_pkg::FN_YIELD) begin
          tab_we = 1'b1;
        end else begin
          active_d = srch_map;
        end
        if (nx_found) begin
          run_d      = nx_idx;
          res_slot_d = rrts_pkg::SlotW'(nx_idx);
          res_sp_d   = nx_sp;
        end else begin
          res_status_d = rrts_pkg::ST_NO_ACTIVE;
          res_slot_d   = rrts_pkg::SlotW'(run_q);
        end
      end
      default: begin
        res_status_d = rrts_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      run_q    <= '0;
    end else if (cmd_i.commit) begin
      active_q <= active_d;
      run_q    <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && tab_we) begin
      sp_tab_q[tab_waddr] <= tab_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      sp_q    <= current_sp_i;
      entry_q <= entry_addr_i;
    end
    if (cmd_i.commit) begin
      status_res_o <= res_status_d;
      slot_id_o    <= res_slot_d;
      stack_ptr_o  <= res_sp_d;
      bank_psw_o   <= res_psw_d;
      start_addr_o <= res_addr_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/round_robin_thread_scheduler.sv -----
// Top level of the round-robin thread scheduler: APB configuration registers,
// controller and datapath. Depends on rrts_pkg, rrts_ctrl and rrts_datapath.
`default_nettype none

// A transaction is accepted at a rising edge where start is high and busy is
// low. The accepting edge captures the command, and the busy state then
// runs the free-slot search or the round-robin search over the slots and
// commits the new scheduler state. The result appears on the result ports
// with result_valid_o high for exactly one cycle after the busy state; in
// that same cycle the next transaction may already be accepted, but none is
// taken while busy is high. The receiver cannot stall: a result must be
// captured in the cycle its strobe is high. Function code 3 is ignored and
// produces no result. Configuration registers stack_base (address 0) and
// stack_stride (address 4) are written through the APB port and must only
// change while no transaction is pending.

module round_robin_thread_scheduler #(
  parameter int unsigned ThreadSlots = rrts_pkg::ThreadSlots
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Command channel.
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    func_i,
  input  wire logic [rrts_pkg::SpW-1:0]      current_sp_i,
  input  wire logic [rrts_pkg::AddrW-1:0]    entry_addr_i,
  // Result channel.
  output logic                               result_valid_o,
  output logic [1:0]                         status_o,
  output logic [rrts_pkg::SlotW-1:0]         slot_id_o,
  output logic [rrts_pkg::SpW-1:0]           stack_ptr_o,
  output logic [rrts_pkg::PswW-1:0]          bank_psw_o,
  output logic [rrts_pkg::AddrW-1:0]         start_addr_o,
  // APB configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rrts_pkg::PaddrW-1:0]   paddr,
  input  wire logic [rrts_pkg::PdataW-1:0]   pwdata,
  output logic [rrts_pkg::PdataW-1:0]        prdata,
  output logic                               pready
);

  localparam int unsigned SpW = rrts_pkg::SpW;

  logic [SpW-1:0] stack_base_q;
  logic [SpW-1:0] stack_stride_q;
  logic           cfg_wr;
  logic [SpW-1:0] cfg_rd;

  rrts_pkg::dp_cmd_t    dp_cmd;
  rrts_pkg::dp_status_t dp_status;

  // The register index is carried by address bit 2; writes take effect in
  // the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_base_q   <= rrts_pkg::StackBaseRst;
      stack_stride_q <= rrts_pkg::StackStrideRst;
    end else if (cfg_wr) begin
      unique case (rrts_pkg::reg_idx_e'(paddr[2]))
        rrts_pkg::REG_STACK_BASE:   stack_base_q   <= pwdata[SpW-1:0];
        rrts_pkg::REG_STACK_STRIDE: stack_stride_q <= pwdata[SpW-1:0];
        default: begin
          stack_base_q <= stack_base_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (rrts_pkg::reg_idx_e'(paddr[2]))
      rrts_pkg::REG_STACK_BASE:   cfg_rd = stack_base_q;
      rrts_pkg::REG_STACK_STRIDE: cfg_rd = stack_stride_q;
      default:                    cfg_rd = '0;
    endcase
  end

  assign prdata = rrts_pkg::PdataW'(cfg_rd);

  // The controller sequences capture and commit; it also owns the strobe.
  rrts_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .status_i       (dp_status),
    .cmd_o          (dp_cmd),
    .result_valid_o (result_valid_o)
  );

  // The datapath holds the slot bitmap, the running slot, the saved stack
  // pointers and the registered result fields.
  rrts_datapath #(
    .ThreadSlots (ThreadSlots)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .func_i         (func_i),
    .current_sp_i   (current_sp_i),
    .entry_addr_i   (entry_addr_i),
    .stack_base_i   (stack_base_q),
    .stack_stride_i (stack_stride_q),
    .status_res_o   (status_o),
    .slot_id_o      (slot_id_o),
    .stack_ptr_o    (stack_ptr_o),
    .bank_psw_o     (bank_psw_o),
    .start_addr_o   (start_addr_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/rrts_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the round-robin thread scheduler: tracks the APB writes,
// predicts every accepted command and compares each result field by field.
// Depends on rrts_pkg for widths, codes and reset constants.

module rrts_checker #(
  parameter int unsigned ThreadSlots = rrts_pkg::ThreadSlots
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [1:0]                  func_i,
  input  logic [rrts_pkg::SpW-1:0]    current_sp_i,
  input  logic [rrts_pkg::AddrW-1:0]  entry_addr_i,
  input  logic                        result_valid_i,
  input  logic [1:0]                  status_i,
  input  logic [rrts_pkg::SlotW-1:0]  slot_id_i,
  input  logic [rrts_pkg::SpW-1:0]    stack_ptr_i,
  input  logic [rrts_pkg::PswW-1:0]   bank_psw_i,
  input  logic [rrts_pkg::AddrW-1:0]  start_addr_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [rrts_pkg::PaddrW-1:0] paddr_i,
  input  logic [rrts_pkg::PdataW-1:0] pwdata_i,
  input  logic                        pready_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import rrts_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [SlotW-1:0]   slot;
    logic [SpW-1:0]     sp;
    logic [PswW-1:0]    psw;
    logic [AddrW-1:0]   addr;
  } sched_result_t;

  logic [SpW-1:0]         base_q;
  logic [SpW-1:0]         stride_q;
  logic [ThreadSlots-1:0] active_q;
  logic [SpW-1:0]         saved_sp_q [ThreadSlots];
  logic [SlotW-1:0]       running_q;
  sched_result_t          expected_q [$];
  sched_result_t          predicted;
  sched_result_t          oldest;

  // Moves to the next active slot after the running one; the running slot is
  // tested last. With nothing active the running slot is kept.
  function automatic void switch_next(output sched_result_t res);
    int cand;
    bit found;
    res = '0;
    res.status = ST_NO_ACTIVE;
    res.slot = running_q;
    found = 1'b0;
    for (int n = 1; n <= ThreadSlots; n++) begin
      cand = (int'(running_q) + n) % ThreadSlots;
      if (!found && active_q[cand]) begin
        found = 1'b1;
        running_q = cand[SlotW-1:0];
        res.status = ST_OK;
        res.slot = cand[SlotW-1:0];
        res.sp = saved_sp_q[cand];
      end
    end
  endfunction

  // Applies one command to the scheduler state. Returns 0 when the command
  // produces no result.
  function automatic bit schedule_step(input logic [1:0] fn, input logic [SpW-1:0] sp,
                                       input logic [AddrW-1:0] addr,
                                       output sched_result_t res);
    int slot;
    res = '0;
    case (fn)
      FN_CREATE: begin
        slot = -1;
        for (int s = ThreadSlots - 1; s >= 0; s--) begin
          if (!active_q[s]) slot = s;
        end
        if (slot < 0) begin
          res.status = ST_NO_FREE;
        end else begin
          active_q[slot] = 1'b1;
          saved_sp_q[slot] = SpW'(int'(base_q) + slot * int'(stride_q) + int'(FrameBytes));
          res.slot = slot[SlotW-1:0];
          res.sp = saved_sp_q[slot];
          res.psw = PswW'(slot << 3);
          res.addr = addr;
        end
      end
      FN_YIELD: begin
        saved_sp_q[running_q] = sp;
        switch_next(res);
      end
      FN_EXIT: begin
        active_q[running_q] = 1'b0;
        switch_next(res);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q = StackBaseRst;
      stride_q = StackStrideRst;
      active_q = '0;
      running_q = '0;
      for (int k = 0; k < ThreadSlots; k++) saved_sp_q[k] = '0;
      expected_q.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      // Results are checked before the command accepted at this same edge
      // is queued, since they belong to earlier commands.
      if (result_valid_i === 1'b1) begin
        if (expected_q.size() == 0) begin
          $error("result arrived with no command outstanding");
          fail_count_o++;
        end else begin
          oldest = expected_q.pop_front();
          if (status_i !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, status_i);
            fail_count_o++;
          end
          if (slot_id_i !== oldest.slot) begin
            $error("slot_id: expected %0d, actual %0d", oldest.slot, slot_id_i);
            fail_count_o++;
          end
          if (stack_ptr_i !== oldest.sp) begin
            $error("stack_ptr: expected 0x%02h, actual 0x%02h", oldest.sp, stack_ptr_i);
            fail_count_o++;
          end
          if (bank_psw_i !== oldest.psw) begin
            $error("bank_psw: expected 0x%02h, actual 0x%02h", oldest.psw, bank_psw_i);
            fail_count_o++;
          end
          if (start_addr_i !== oldest.addr) begin
            $error("start_addr: expected 0x%04h, actual 0x%04h", oldest.addr, start_addr_i);
            fail_count_o++;
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (reg_idx_e'(paddr_i[2]) == REG_STACK_BASE) base_q = pwdata_i[SpW-1:0];
        else stride_q = pwdata_i[SpW-1:0];
      end
      if (start_i && !busy_i) begin
        if (schedule_step(func_i, current_sp_i, entry_addr_i, predicted))
          expected_q.push_back(predicted);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ----- tb/sv/round_robin_thread_scheduler_tb.sv -----
`timescale 1ns / 1ps
// Top of the round-robin thread scheduler testbench: clock, reset, APB setup
// and command stimulus, plus the verdict. Depends on rrts_pkg, the scheduler
// RTL and the rrts_checker scoreboard.

module round_robin_thread_scheduler_tb;
  import rrts_pkg::*;

  // Function code 3 is not defined; the scheduler must drop it silently.
  localparam logic [1:0] FnUnused = 2'd3;
  // Generous bound on the whole run, far above the slowest legal run.
  localparam int CycleLimit = 400000;
  // Commands per random phase; five phases give the full random budget.
  localparam int PhaseItems = 380;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         func;
  logic [SpW-1:0]     current_sp;
  logic [AddrW-1:0]   entry_addr;
  logic               result_valid;
  logic [1:0]         status;
  logic [SlotW-1:0]   slot_id;
  logic [SpW-1:0]     stack_ptr;
  logic [PswW-1:0]    bank_psw;
  logic [AddrW-1:0]   start_addr;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PaddrW-1:0]  paddr;
  logic [PdataW-1:0]  pwdata;
  logic [PdataW-1:0]  prdata;
  logic               pready;

  int fail_count;
  int pending;
  int cycle_count = 0;
  // Upper bound of the idle gap drawn before each command; changed per chunk
  // so that long gaps, short gaps and back-to-back stretches all occur.
  int idle_max;

  round_robin_thread_scheduler u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func),
    .current_sp_i   (current_sp),
    .entry_addr_i   (entry_addr),
    .result_valid_o (result_valid),
    .status_o       (status),
    .slot_id_o      (slot_id),
    .stack_ptr_o    (stack_ptr),
    .bank_psw_o     (bank_psw),
    .start_addr_o   (start_addr),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // The scoreboard sees the same pins as the scheduler and keeps its own
  // copy of the slot state and configuration.
  rrts_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .func_i         (func),
    .current_sp_i   (current_sp),
    .entry_addr_i   (entry_addr),
    .result_valid_i (result_valid),
    .status_i       (status),
    .slot_id_i      (slot_id),
    .stack_ptr_i    (stack_ptr),
    .bank_psw_i     (bank_psw),
    .start_addr_i   (start_addr),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hang anywhere in the handshakes ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Issues one command transaction. The task is entered on a rising edge and
  // returns on the edge that accepted the command. Start is only lowered when
  // a gap is drawn, so a back-to-back command never sees start dropped and
  // raised within one time step.
  task automatic send(input logic [1:0] fn, input logic [SpW-1:0] sp,
                      input logic [AddrW-1:0] addr);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    func <= fn;
    current_sp <= sp;
    entry_addr <= addr;
    do @(posedge clk_i); while (busy);
  endtask

  // Holds off the sender until every predicted result has come back. The
  // count is read at the falling edge, away from the scoreboard's updates.
  // The extra cycles let an ignored function code finish inside the block.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One APB write: setup phase, access phase, then an idle phase so that
  // the next write never lowers and raises psel in the same step.
  task automatic apb_write(input reg_idx_e idx, input logic [SpW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= PdataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // The registers may only change with no command in flight.
  task automatic set_config(input logic [SpW-1:0] base, input logic [SpW-1:0] stride);
    drain_results();
    apb_write(REG_STACK_BASE, base);
    apb_write(REG_STACK_STRIDE, stride);
  endtask

  // Random commands. Each chunk picks its own idle profile and its own mix,
  // so that the slots run full (creates refused) as well as empty (switches
  // with no thread). Ignored codes are mixed in but not counted.
  task automatic run_random(input int count);
    int done;
    int chunk_left;
    int create_pct;
    int r;
    logic [1:0] fn;
    logic [SpW-1:0] sp;
    logic [AddrW-1:0] addr;
    done = 0;
    chunk_left = 0;
    create_pct = 30;
    while (done < count) begin
      if (chunk_left == 0) begin
        chunk_left = 40;
        r = $urandom_range(0, 2);
        idle_max = (r == 0) ? 0 : (r == 1) ? 3 : 12;
        create_pct = $urandom_range(10, 50);
      end
      // Now and then the sender waits for the block to empty completely.
      if ($urandom_range(0, 59) == 0) drain_results();
      r = $urandom_range(0, 99);
      if (r < 5) fn = FnUnused;
      else if (r < 5 + create_pct) fn = FN_CREATE;
      else if (r < 25 + create_pct) fn = FN_EXIT;
      else fn = FN_YIELD;
      r = $urandom_range(0, 9);
      sp = (r == 0) ? '0 : (r == 1) ? '1 : SpW'($urandom_range(0, 255));
      addr = (r == 2) ? '0 : (r == 3) ? '1 : AddrW'($urandom_range(0, 65535));
      send(fn, sp, addr);
      if (fn != FnUnused) begin
        done++;
        chunk_left--;
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    func <= FN_CREATE;
    current_sp <= '0;
    entry_addr <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    idle_max = 2;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset configuration. With no thread alive,
    // yield and exit both report that nothing is active; the yield still
    // stores its stack pointer for the free running slot.
    send(FN_YIELD, 8'hFF, 16'h0000);
    send(FN_EXIT, 8'h00, 16'hFFFF);
    send(FnUnused, 8'hAA, 16'h5555);
    // Fill every slot, then one create too many.
    send(FN_CREATE, 8'h00, 16'h0000);
    send(FN_CREATE, 8'hFF, 16'hFFFF);
    send(FN_CREATE, 8'h12, 16'h1234);
    send(FN_CREATE, 8'h80, 16'h8001);
    send(FN_CREATE, 8'h01, 16'hBEEF);
    // Walk the ring with saved pointers at the extremes.
    send(FN_YIELD, 8'h00, 16'hFFFF);
    send(FN_YIELD, 8'hFF, 16'h0000);
    send(FN_YIELD, 8'h5A, 16'hA5A5);
    send(FN_YIELD, 8'hA5, 16'h5A5A);
    send(FN_YIELD, 8'h11, 16'h0000);
    send(FnUnused, 8'h00, 16'h0000);
    // Retire every thread, then switch again with none left.
    send(FN_EXIT, 8'hFF, 16'hFFFF);
    send(FN_EXIT, 8'h00, 16'h0000);
    send(FN_YIELD, 8'h33, 16'h0000);
    send(FN_EXIT, 8'h00, 16'h0000);
    send(FN_EXIT, 8'h00, 16'h0000);
    send(FN_EXIT, 8'h00, 16'h0000);
    send(FN_YIELD, 8'h77, 16'h0000);
    // A freed slot is reused by the next create.
    send(FN_CREATE, 8'h00, 16'hC0DE);
    send(FN_YIELD, 8'hEE, 16'h0000);

    run_random(PhaseItems);
    set_config(8'h00, 8'h00);
    run_random(PhaseItems);
    set_config(8'hFF, 8'hFF);
    run_random(PhaseItems);
    set_config(SpW'($urandom_range(0, 255)), SpW'($urandom_range(0, 255)));
    run_random(PhaseItems);
    set_config(8'hFF, 8'h00);
    run_random(PhaseItems);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
